FILE: hw/rtl/msek_pkg.sv
// ----------------------------------------------------------------------------
// msek_pkg
// Shared types and constants of the multi-stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

package msek_pkg;

  localparam int DATA_W            = 32;
  localparam int OP_W              = 2;
  localparam int INDEX_W           = 4;
  localparam int NUM_STACKS_DEF    = 8;
  localparam int STACK_DEPTH_DEF   = 64;
  localparam int QUEUE_DEPTH       = 4;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_STATUS = 2'd0,
    K_PUSH   = 2'd1,
    K_POP    = 2'd2,
    K_DUMP   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e   kind;
    status_e status;
  } msek_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/multi_stack_engine_core.sv
// ----------------------------------------------------------------------------
// multi_stack_engine_core
// Several fixed-depth stacks of 32-bit words sharing one store.
//
//   channel   signals                              handshake
//   command   op_i, stack_index_i, value_i         start & !busy
//   result    status_o, data_o, last_o             valid_o, one cycle, no stall
//
// outside a dump, the back end takes push, pop and error commands one per cycle;
// a dump returns its stored words one per cycle, set by the single store read port
// a result is registered in the queue and then in the back-end output registers
// a queue of four words sits between front and back; busy is high while it is full
// reset clears all occupancy counts and the queue; store contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_engine_core import msek_pkg::*; #(
  parameter int NUM_STACKS  = NUM_STACKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [OP_W-1:0]           op_i,
  input  wire logic [INDEX_W-1:0]        stack_index_i,
  input  wire logic signed [DATA_W-1:0]  value_i,
  output logic                           valid_o,
  output logic [1:0]                     status_o,
  output logic signed [DATA_W-1:0]       data_o,
  output logic                           last_o
);

  localparam int SIDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int CTL_W   = $bits(msek_ctl_t);
  localparam int ENTRY_W = CTL_W + SIDX_W + CNT_W + DATA_W;

  logic              q_full, q_push, q_pop, q_valid;
  msek_ctl_t         f_ctl, b_ctl;
  logic [SIDX_W-1:0] f_sidx, b_sidx;
  logic [CNT_W-1:0]  f_cnt, b_cnt;
  logic [DATA_W-1:0] f_value, b_value;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic [DATA_W-1:0] data;

  msek_front #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH),
    .SIDX_W      (SIDX_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .stack_index_i (stack_index_i),
    .value_i       (value_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .ctl_o         (f_ctl),
    .sidx_o        (f_sidx),
    .cnt_o         (f_cnt),
    .value_o       (f_value)
  );

  assign q_wdata = {f_ctl, f_sidx, f_cnt, f_value};

  msek_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {b_ctl, b_sidx, b_cnt, b_value} = q_rdata;

  msek_back #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH),
    .SIDX_W      (SIDX_W),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .ctl_i     (b_ctl),
    .sidx_i    (b_sidx),
    .cnt_i     (b_cnt),
    .value_i   (b_value),
    .valid_o   (valid_o),
    .status_o  (status_o),
    .data_o    (data),
    .last_o    (last_o)
  );

  assign data_o = data;

endmodule

`default_nettype wire

FILE: hw/rtl/msek_queue.sv
// ----------------------------------------------------------------------------
// msek_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module msek_queue import msek_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW:0]      wr_ptr_q, wr_ptr_d;
  logic [PW:0]      rd_ptr_q, rd_ptr_d;

  assign valid_o  = (wr_ptr_q != rd_ptr_q);
  assign full_o   = (wr_ptr_q[PW] != rd_ptr_q[PW]) && (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]);
  assign data_o   = slot_q[rd_ptr_q[PW-1:0]];
  assign wr_ptr_d = wr_ptr_q + (PW+1)'(push_i);
  assign rd_ptr_d = rd_ptr_q + (PW+1)'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q[PW-1:0]] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msek_front.sv
// ----------------------------------------------------------------------------
// msek_front
// Accepts commands, tracks stack occupancy and classifies each command.
// ----------------------------------------------------------------------------
`default_nettype none

module msek_front import msek_pkg::*; #(
  parameter int NUM_STACKS  = NUM_STACKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int SIDX_W      = 3,
  parameter int CNT_W       = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     op_i,
  input  wire logic [INDEX_W-1:0]  stack_index_i,
  input  wire logic [DATA_W-1:0]   value_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output msek_ctl_t                ctl_o,
  output logic [SIDX_W-1:0]        sidx_o,
  output logic [CNT_W-1:0]         cnt_o,
  output logic [DATA_W-1:0]        value_o
);

  logic [CNT_W-1:0]  occ_q [NUM_STACKS];
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  new_cnt;
  logic              occ_we;
  logic              accept;
  logic              in_range;
  logic [SIDX_W-1:0] sidx;

  assign busy     = q_full_i;
  assign accept   = start && !busy;
  assign in_range = {1'b0, stack_index_i} < (INDEX_W+1)'(NUM_STACKS);
  assign sidx     = stack_index_i[SIDX_W-1:0];
  assign cur_cnt  = occ_q[sidx];
  assign sidx_o   = sidx;
  assign value_o  = value_i;

  always_comb begin
    q_push_o   = 1'b0;
    ctl_o      = '{kind: K_STATUS, status: ST_OK};
    cnt_o      = cur_cnt;
    new_cnt    = cur_cnt;
    occ_we     = 1'b0;
    case (op_i)
      OP_PUSH: begin
        q_push_o = accept;
        if (!in_range) begin
          ctl_o.status = ST_BAD_INDEX;
        end else if (cur_cnt == CNT_W'(STACK_DEPTH)) begin
          ctl_o.status = ST_FULL;
        end else begin
          ctl_o.kind = K_PUSH;
          new_cnt    = cur_cnt + CNT_W'(1);
          occ_we     = accept;
        end
      end
      OP_POP: begin
        q_push_o = accept;
        if (!in_range) begin
          ctl_o.status = ST_BAD_INDEX;
        end else if (cur_cnt == '0) begin
          ctl_o.status = ST_EMPTY;
        end else begin
          ctl_o.kind = K_POP;
          new_cnt    = cur_cnt - CNT_W'(1);
          cnt_o      = new_cnt;
          occ_we     = accept;
        end
      end
      OP_DUMP: begin
        q_push_o = accept;
        if (!in_range) begin
          ctl_o.status = ST_BAD_INDEX;
        end else if (cur_cnt == '0) begin
          ctl_o.status = ST_EMPTY;
        end else begin
          ctl_o.kind = K_DUMP;
        end
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        occ_q[i] <= '0;
      end
    end else if (occ_we) begin
      occ_q[sidx] <= new_cnt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msek_back.sv
// ----------------------------------------------------------------------------
// msek_back
// Executes classified commands against the shared stack store.
// ----------------------------------------------------------------------------
`default_nettype none

module msek_back import msek_pkg::*; #(
  parameter int NUM_STACKS  = NUM_STACKS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int SIDX_W      = 3,
  parameter int CNT_W       = 7
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  output logic                    q_pop_o,
  input  wire msek_ctl_t          ctl_i,
  input  wire logic [SIDX_W-1:0]  sidx_i,
  input  wire logic [CNT_W-1:0]   cnt_i,
  input  wire logic [DATA_W-1:0]  value_i,
  output logic                    valid_o,
  output logic [1:0]              status_o,
  output logic [DATA_W-1:0]       data_o,
  output logic                    last_o
);

  localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  logic              dump_act_q, dump_act_d;
  logic [AW-1:0]     dump_base_q, dump_base_d;
  logic [CNT_W-1:0]  dump_idx_q, dump_idx_d;
  logic [CNT_W-1:0]  dump_cnt_q, dump_cnt_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic              out_last_q, out_last_d;
  logic              out_rd_q, out_rd_d;

  logic              wr_en, rd_en;
  logic [AW-1:0]     base, wr_addr, rd_addr;

  assign base    = AW'(sidx_i * STACK_DEPTH);
  assign q_pop_o = q_valid_i && !dump_act_q;

  always_comb begin
    dump_act_d   = dump_act_q;
    dump_base_d  = dump_base_q;
    dump_idx_d   = dump_idx_q;
    dump_cnt_d   = dump_cnt_q;
    out_valid_d  = 1'b0;
    out_status_d = ST_OK;
    out_last_d   = 1'b1;
    out_rd_d     = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    wr_addr      = base + AW'(cnt_i);
    rd_addr      = base + AW'(cnt_i);
    if (dump_act_q) begin
      out_valid_d = 1'b1;
      out_rd_d    = 1'b1;
      rd_en       = 1'b1;
      rd_addr     = dump_base_q + AW'(dump_idx_q);
      out_last_d  = (dump_idx_q + CNT_W'(1)) == dump_cnt_q;
      dump_idx_d  = dump_idx_q + CNT_W'(1);
      if (out_last_d) begin
        dump_act_d = 1'b0;
      end
    end else if (q_valid_i) begin
      out_valid_d  = 1'b1;
      out_status_d = ctl_i.status;
      case (ctl_i.kind)
        K_PUSH: begin
          wr_en = 1'b1;
        end
        K_POP: begin
          rd_en    = 1'b1;
          out_rd_d = 1'b1;
        end
        K_DUMP: begin
          rd_en       = 1'b1;
          out_rd_d    = 1'b1;
          rd_addr     = base;
          out_last_d  = (cnt_i == CNT_W'(1));
          dump_act_d  = !out_last_d;
          dump_base_d = base;
          dump_idx_d  = CNT_W'(1);
          dump_cnt_d  = cnt_i;
        end
        default: begin
          out_rd_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_act_q   <= 1'b0;
      dump_base_q  <= '0;
      dump_idx_q   <= '0;
      dump_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
      out_rd_q     <= 1'b0;
    end else begin
      dump_act_q   <= dump_act_d;
      dump_base_q  <= dump_base_d;
      dump_idx_q   <= dump_idx_d;
      dump_cnt_q   <= dump_cnt_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
      out_rd_q     <= out_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign valid_o  = out_valid_q;
  assign status_o = out_status_q;
  assign last_o   = out_last_q;
  assign data_o   = out_rd_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-stack engine core. A shadow copy of every
// stack predicts the words each command should return; results are matched
// in order, field by field, as they stream out. Directed cases cover empty and
// invalid-stack errors, the unused opcode and the data extremes, then random
// fill (hitting full), push, pop and dump runs follow under varying start gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import msek_pkg::*;

  localparam int NS = NUM_STACKS_DEF;
  localparam int SD = STACK_DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    status_e            status;
    logic signed [31:0] data;
    logic               last;
  } word_t;

  class stack_tracker;
    int unsigned depth_count[NS];
    bit [31:0]   words[NS][SD];
    word_t       pending_words[$];
    int          errors;

    function new();
      errors = 0;
      foreach (depth_count[s]) depth_count[s] = 0;
    endfunction

    function void add_word(status_e st, logic [31:0] d, logic l);
      word_t w;
      w.status = st;
      w.data   = d;
      w.last   = l;
      pending_words.push_back(w);
    endfunction

    function void note_command(logic [1:0] op, logic [3:0] idx, logic [31:0] val);
      int unsigned n;
      if (op == OP_UNUSED) return;
      if (idx >= NS) begin
        add_word(ST_BAD_INDEX, '0, 1'b1);
        return;
      end
      n = depth_count[idx];
      case (op)
        OP_PUSH: begin
          if (n >= SD) begin
            add_word(ST_FULL, '0, 1'b1);
          end else begin
            words[idx][n]   = val;
            depth_count[idx] = n + 1;
            add_word(ST_OK, '0, 1'b1);
          end
        end
        OP_POP: begin
          if (n == 0) begin
            add_word(ST_EMPTY, '0, 1'b1);
          end else begin
            depth_count[idx] = n - 1;
            add_word(ST_OK, words[idx][n-1], 1'b1);
          end
        end
        default: begin
          if (n == 0) begin
            add_word(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) add_word(ST_OK, words[idx][i], (i + 1 == n));
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [1:0] st, logic [31:0] d, logic l);
      word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word status=%0d data=%h last=%0b", st, d, l));
        return;
      end
      w = pending_words.pop_front();
      if (st !== w.status) report($sformatf("status %0d, expected %0d", st, w.status));
      if (d !== w.data) report($sformatf("data %h, expected %h", d, w.data));
      if (l !== w.last) report($sformatf("last %0b, expected %0b", l, w.last));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [OP_W-1:0]           op_i = '0;
  logic [INDEX_W-1:0]        stack_index_i = '0;
  logic signed [DATA_W-1:0]  value_i = '0;
  logic                      valid_o;
  logic [1:0]                status_o;
  logic signed [DATA_W-1:0]  data_o;
  logic                      last_o;

  stack_tracker trk;
  int           idle_pct;
  int           sent_cmds;

  multi_stack_engine_core #(
    .NUM_STACKS  (NS),
    .STACK_DEPTH (SD)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .stack_index_i (stack_index_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .data_o        (data_o),
    .last_o        (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) trk.check_word(status_o, data_o, last_o);
  end

  task send_word(logic [1:0] op, logic [3:0] idx, logic [31:0] val);
    start         <= 1'b1;
    op_i          <= op;
    stack_index_i <= idx;
    value_i       <= val;
    do @(posedge clk_i); while (busy);
    trk.note_command(op, idx, val);
    if (op != OP_UNUSED) sent_cmds++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task fill_stack(int s);
    while (trk.depth_count[s] < SD) send_word(OP_PUSH, 4'(s), $urandom);
    repeat ($urandom_range(1, 2)) send_word(OP_PUSH, 4'(s), $urandom);
    send_word(OP_DUMP, 4'(s), $urandom);
  endtask

  task run_phase(int pct, int target);
    int goal;
    int s;
    int r;
    idle_pct = pct;
    goal = sent_cmds + target;
    fill_stack($urandom_range(0, NS - 1));
    while (sent_cmds < goal) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, NS - 1);
      if (r < 35) begin
        repeat ($urandom_range(1, 12)) send_word(OP_PUSH, 4'(s), $urandom);
      end else if (r < 60) begin
        repeat ($urandom_range(1, 8)) send_word(OP_POP, 4'(s), $urandom);
      end else if (r < 75) begin
        send_word(OP_DUMP, 4'(s), $urandom);
      end else if (r < 85) begin
        send_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
      end else begin
        send_word(2'($urandom_range(0, 2)), 4'($urandom_range(NS, 15)), $urandom);
      end
    end
  endtask

  initial begin
    trk = new();
    idle_pct = 0;
    sent_cmds = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty, extremes, invalid stacks, unused opcode
    send_word(OP_POP,    0,  32'h1234_5678);
    send_word(OP_DUMP,   1,  32'hffff_ffff);
    send_word(OP_PUSH,   0,  32'h8000_0000);
    send_word(OP_PUSH,   0,  32'h7fff_ffff);
    send_word(OP_PUSH,   7,  32'h0000_0000);
    send_word(OP_PUSH,   7,  32'hffff_ffff);
    send_word(OP_DUMP,   0,  32'h0);
    send_word(OP_POP,    0,  32'h0);
    send_word(OP_POP,    0,  32'h0);
    send_word(OP_POP,    0,  32'h0);
    send_word(OP_PUSH,   8,  32'h5555_5555);
    send_word(OP_POP,    8,  32'haaaa_aaaa);
    send_word(OP_DUMP,   15, 32'h0);
    send_word(OP_PUSH,   15, 32'hffff_ffff);
    send_word(OP_UNUSED, 3,  32'hdead_beef);
    send_word(OP_UNUSED, 15, 32'hffff_ffff);
    send_word(OP_DUMP,   7,  32'h0);
    send_word(OP_POP,    7,  32'h0);
    send_word(OP_POP,    7,  32'h0);
    send_word(OP_DUMP,   7,  32'h0);

    run_phase(8, 115);
    run_phase(55, 115);
    run_phase(0, 115);

    start <= 1'b0;
    while (trk.pending_words.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (trk.errors == 0 && trk.pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/msek_pkg.sv
hw/rtl/msek_queue.sv
hw/rtl/msek_front.sv
hw/rtl/msek_back.sv
hw/rtl/multi_stack_engine_core.sv
dv/tb_top.sv
